[sv/rectangle_rotate_about_center_assert.svh]
// Assertion macros for the rectangle rotation block.
`ifndef RECTANGLE_ROTATE_ABOUT_CENTER_ASSERT_SVH
`define RECTANGLE_ROTATE_ABOUT_CENTER_ASSERT_SVH

// Same-cycle implication, sampled on clock, idle during reset.
`define RRAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, idle during reset.
`define RRAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/rrac_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the rectangle rotation block.
package rrac_pkg;

   // Field widths.
   localparam int COORD_BITS         = 10;
   localparam int TRIG_FRAC_BITS_DEF = 14;
   localparam int ANGLE_BITS         = 16;
   localparam int OUT_BITS           = 12;
   localparam int CORNER_BITS        = 2;

   // Angle reduction: bias the angle by a multiple of 360 so it is never negative,
   // then take the quotient by a reciprocal multiply.
   localparam int DEG_FULL     = 360;
   localparam int DEG_QUARTER  = 90;
   localparam int DEG_BITS     = 9;
   localparam int K_BITS       = 7;
   localparam int ANGLE_BIAS   = DEG_FULL * ((2 ** (ANGLE_BITS - 1) + DEG_FULL - 1) / DEG_FULL);
   localparam int U_BITS       = ANGLE_BITS + 1;
   localparam int RECIP_SHIFT  = 26;
   localparam int RECIP_BITS   = 18;
   localparam int RECIP_360    = (2 ** RECIP_SHIFT + DEG_FULL - 1) / DEG_FULL;
   localparam int QUOT_BITS    = 8;

   // Sine table format.
   localparam int TABLE_FRAC = 16;
   localparam int TABLE_BITS = TABLE_FRAC + 1;

   localparam logic [CORNER_BITS-1:0] FIRST_CORNER = 2'd0;
   localparam logic [CORNER_BITS-1:0] LAST_CORNER  = 2'd3;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [COORD_BITS:0]   delta_type;

   typedef struct packed {
      coord_type                   left_x;
      coord_type                   top_y;
      coord_type                   right_x;
      coord_type                   bottom_y;
      logic signed [ANGLE_BITS-1:0] angle_degrees;
   } req_type;

   typedef struct packed {
      logic [CORNER_BITS-1:0]     corner_index;
      logic signed [OUT_BITS-1:0] rotated_x;
      logic signed [OUT_BITS-1:0] rotated_y;
      logic                       last_corner;
   } rsp_type;

   // Center and corner offsets of one rectangle.
   typedef struct packed {
      coord_type center_x;
      coord_type center_y;
      delta_type dx_left;
      delta_type dx_right;
      delta_type dy_top;
      delta_type dy_bottom;
   } geom_type;

   // sin(k degrees) for k = 0..90, unsigned with 16 fraction bits, rounded to nearest.
   localparam logic [TABLE_BITS-1:0] QUARTER_SINE [0:DEG_QUARTER] = '{
      17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
      17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
      17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
      17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
      17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
      17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
      17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
      17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
      17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
      17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
      17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
      17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
      17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
   };

endpackage

[sv/rrac_trig.sv]
// Front pipeline: input register, angle reduction, quadrant split, sine and cosine lookup.
module rrac_trig import rrac_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  req_type                         req,
   output logic                            trig_valid,
   input  logic                            trig_ready,
   output logic signed [TRIG_FRAC_BITS+1:0] trig_sin,
   output logic signed [TRIG_FRAC_BITS+1:0] trig_cos,
   output geom_type                        trig_geom
);

   localparam int F        = TRIG_FRAC_BITS;
   localparam int TRIG_W   = F + 2;
   localparam int SHIFT    = TABLE_FRAC - F;
   localparam int HALF_INT = (2 ** SHIFT) / 2;
   localparam logic [TABLE_BITS:0] HALF = (TABLE_BITS + 1)'(HALF_INT);
   localparam int PROD_BITS = U_BITS + RECIP_BITS;

   localparam logic [RECIP_BITS-1:0] RECIP   = RECIP_BITS'(RECIP_360);
   localparam logic [DEG_BITS-1:0]   DEG_90  = DEG_BITS'(DEG_QUARTER);
   localparam logic [DEG_BITS-1:0]   DEG_180 = DEG_BITS'(2 * DEG_QUARTER);
   localparam logic [DEG_BITS-1:0]   DEG_270 = DEG_BITS'(3 * DEG_QUARTER);
   localparam logic [K_BITS-1:0]     K_90    = K_BITS'(DEG_QUARTER);

   // Table entry reduced to F fraction bits, rounding half up.
   function automatic logic [F:0] trig_round(input logic [TABLE_BITS-1:0] entry);
      logic [TABLE_BITS:0] sum;
      sum = {1'b0, entry} + HALF;
      return (F + 1)'(sum >> SHIFT);
   endfunction

   // Stage registers.
   logic                  s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic                  s0_free, s1_free, s2_free;
   req_type               s0_req_ff;
   logic [U_BITS-1:0]     s1_u_ff;
   logic [QUOT_BITS-1:0]  s1_quot_ff;
   geom_type              s1_geom_ff, s2_geom_ff;
   logic [1:0]            s2_quad_ff;
   logic [K_BITS-1:0]     s2_k_ff;

   // Next values.
   logic signed [U_BITS:0] biased;
   logic [U_BITS-1:0]      u_in;
   logic [PROD_BITS-1:0]   recip_prod;
   logic [QUOT_BITS-1:0]   quot_in;
   logic [COORD_BITS:0]    sum_x, sum_y;
   geom_type               geom_in;
   logic [DEG_BITS-1:0]    deg;
   logic [1:0]             quad_in;
   logic [DEG_BITS-1:0]    quad_base;
   logic [K_BITS-1:0]      k_in;

   // Each stage moves when the one after it is empty or moving.
   assign s2_free   = !s2_valid_ff || trig_ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign s0_free   = !s0_valid_ff || s1_free;
   assign req_ready = s0_free;

   // First step: bias the angle, multiply by the reciprocal of 360, and find the center.
   always_comb begin
      biased     = (U_BITS + 1)'(s0_req_ff.angle_degrees) + (U_BITS + 1)'(ANGLE_BIAS);
      u_in       = biased[U_BITS-1:0];
      recip_prod = PROD_BITS'(u_in) * PROD_BITS'(RECIP);
      quot_in    = recip_prod[RECIP_SHIFT +: QUOT_BITS];

      sum_x = {1'b0, s0_req_ff.left_x} + {1'b0, s0_req_ff.right_x};
      sum_y = {1'b0, s0_req_ff.top_y} + {1'b0, s0_req_ff.bottom_y};
      geom_in.center_x  = sum_x[COORD_BITS:1];
      geom_in.center_y  = sum_y[COORD_BITS:1];
      geom_in.dx_left   = $signed({1'b0, s0_req_ff.left_x})   - $signed({1'b0, geom_in.center_x});
      geom_in.dx_right  = $signed({1'b0, s0_req_ff.right_x})  - $signed({1'b0, geom_in.center_x});
      geom_in.dy_top    = $signed({1'b0, s0_req_ff.top_y})    - $signed({1'b0, geom_in.center_y});
      geom_in.dy_bottom = $signed({1'b0, s0_req_ff.bottom_y}) - $signed({1'b0, geom_in.center_y});
   end

   // Second step: remainder in 0..359, then quadrant and offset inside it.
   always_comb begin
      deg = DEG_BITS'(s1_u_ff - U_BITS'(s1_quot_ff * DEG_FULL));
      if (deg >= DEG_270) begin
         quad_in   = 2'd3;
         quad_base = DEG_270;
      end else if (deg >= DEG_180) begin
         quad_in   = 2'd2;
         quad_base = DEG_180;
      end else if (deg >= DEG_90) begin
         quad_in   = 2'd1;
         quad_base = DEG_90;
      end else begin
         quad_in   = 2'd0;
         quad_base = '0;
      end
      k_in = K_BITS'(deg - quad_base);
   end

   // Third step: two table reads and the quadrant signs, registered downstream.
   always_comb begin
      logic signed [TRIG_W-1:0] a_pos, b_pos;
      a_pos = $signed({1'b0, trig_round(QUARTER_SINE[s2_k_ff])});
      b_pos = $signed({1'b0, trig_round(QUARTER_SINE[K_90 - s2_k_ff])});
      case (s2_quad_ff)
         2'd0: begin
            trig_sin = a_pos;
            trig_cos = b_pos;
         end
         2'd1: begin
            trig_sin = b_pos;
            trig_cos = -a_pos;
         end
         2'd2: begin
            trig_sin = -a_pos;
            trig_cos = -b_pos;
         end
         default: begin
            trig_sin = -b_pos;
            trig_cos = a_pos;
         end
      endcase
   end

   assign trig_valid = s2_valid_ff;
   assign trig_geom  = s2_geom_ff;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_free) s0_valid_ff <= req_valid;
         if (s1_free) s1_valid_ff <= s0_valid_ff;
         if (s2_free) s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (req_valid && s0_free) begin
         s0_req_ff <= req;
      end
      if (s0_valid_ff && s1_free) begin
         s1_u_ff    <= u_in;
         s1_quot_ff <= quot_in;
         s1_geom_ff <= geom_in;
      end
      if (s1_valid_ff && s2_free) begin
         s2_quad_ff <= quad_in;
         s2_k_ff    <= k_in;
         s2_geom_ff <= s1_geom_ff;
      end
   end

endmodule

[sv/rrac_corner.sv]
// Corner sequencer: holds one rectangle, forms rotation products per corner, rounds and saturates.
module rrac_corner import rrac_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             trig_valid,
   output logic                             trig_ready,
   input  logic signed [TRIG_FRAC_BITS+1:0] trig_sin,
   input  logic signed [TRIG_FRAC_BITS+1:0] trig_cos,
   input  geom_type                         trig_geom,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output rsp_type                          rsp
);

   localparam int F      = TRIG_FRAC_BITS;
   localparam int TRIG_W = F + 2;
   localparam int PROD_W = COORD_BITS + 1 + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int QUO_W  = SUM_W - F;

   localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'((64'd1 << F) - 64'd1);
   localparam logic signed [QUO_W-1:0] SAT_LO    = QUO_W'(-(2 ** (OUT_BITS - 1)));
   localparam logic signed [QUO_W-1:0] SAT_HI    = QUO_W'(2 ** (OUT_BITS - 1) - 1);

   // Divide by 2^F toward zero, then clamp to the output range.
   function automatic logic signed [OUT_BITS-1:0] trunc_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0]    adj;
      logic signed [QUO_W-1:0]    q;
      logic signed [OUT_BITS-1:0] res;
      adj = v[SUM_W-1] ? v + ROUND_ADD : v;
      q   = QUO_W'(adj >>> F);
      if (q < SAT_LO) begin
         res = OUT_BITS'(SAT_LO);
      end else if (q > SAT_HI) begin
         res = OUT_BITS'(SAT_HI);
      end else begin
         res = OUT_BITS'(q);
      end
      return res;
   endfunction

   // Held rectangle and corner counter.
   logic                     s3_valid_ff;
   logic [CORNER_BITS-1:0]   corner_ff;
   logic signed [TRIG_W-1:0] sin_ff, cos_ff;
   geom_type                 geom_ff;

   // Product stage.
   logic                     s4_valid_ff;
   logic [CORNER_BITS-1:0]   s4_corner_ff;
   logic signed [PROD_W-1:0] dxc_ff, dxs_ff, dyc_ff, dys_ff;
   logic signed [SUM_W-1:0]  base_x_ff, base_y_ff;

   // Output register.
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   logic                     out_free, s4_free, s3_step;
   delta_type                dx_sel, dy_sel;
   logic signed [PROD_W-1:0] dxc_in, dxs_in, dyc_in, dys_in;
   logic signed [SUM_W-1:0]  base_x_in, base_y_in;
   logic signed [SUM_W-1:0]  sum_x, sum_y;
   rsp_type                  rsp_in;

   // Flow control: one corner leaves the held rectangle per cycle when the product stage can take it.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s4_free    = !s4_valid_ff || out_free;
   assign s3_step    = s3_valid_ff && s4_free;
   assign trig_ready = !s3_valid_ff || (s3_step && (corner_ff == LAST_CORNER));

   // Corner select: x from the left side for corners 0 and 1, y from the bottom for 1 and 2.
   always_comb begin
      dx_sel    = corner_ff[1] ? geom_ff.dx_right : geom_ff.dx_left;
      dy_sel    = (corner_ff[1] ^ corner_ff[0]) ? geom_ff.dy_bottom : geom_ff.dy_top;
      dxc_in    = PROD_W'(dx_sel) * PROD_W'(cos_ff);
      dxs_in    = PROD_W'(dx_sel) * PROD_W'(sin_ff);
      dyc_in    = PROD_W'(dy_sel) * PROD_W'(cos_ff);
      dys_in    = PROD_W'(dy_sel) * PROD_W'(sin_ff);
      base_x_in = $signed({{(SUM_W - COORD_BITS - F){1'b0}}, geom_ff.center_x, {F{1'b0}}});
      base_y_in = $signed({{(SUM_W - COORD_BITS - F){1'b0}}, geom_ff.center_y, {F{1'b0}}});
   end

   // Sum the scaled center and the products, then round and clamp.
   always_comb begin
      sum_x = base_x_ff + SUM_W'(dxc_ff) - SUM_W'(dys_ff);
      sum_y = base_y_ff + SUM_W'(dxs_ff) + SUM_W'(dyc_ff);
      rsp_in.corner_index = s4_corner_ff;
      rsp_in.rotated_x    = trunc_sat(sum_x);
      rsp_in.rotated_y    = trunc_sat(sum_y);
      rsp_in.last_corner  = (s4_corner_ff == LAST_CORNER);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         corner_ff    <= FIRST_CORNER;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (trig_ready) s3_valid_ff <= trig_valid;
         if (s3_step) corner_ff <= corner_ff + CORNER_BITS'(1);
         if (s4_free) s4_valid_ff <= s3_valid_ff;
         if (out_free) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (trig_valid && trig_ready) begin
         sin_ff  <= trig_sin;
         cos_ff  <= trig_cos;
         geom_ff <= trig_geom;
      end
      if (s3_step) begin
         s4_corner_ff <= corner_ff;
         dxc_ff       <= dxc_in;
         dxs_ff       <= dxs_in;
         dyc_ff       <= dyc_in;
         dys_ff       <= dys_in;
         base_x_ff    <= base_x_in;
         base_y_ff    <= base_y_in;
      end
      if (s4_valid_ff && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[sv/rectangle_rotate_about_center.sv]
// Top level of the rectangle rotation block: rotates the four corners about the center.
//
//   Channel | Direction | Handshake              | Moves per transfer
//   req     | in        | req_valid / req_ready  | one rectangle and angle (req_type)
//   rsp     | out       | rsp_valid / rsp_ready  | one rotated corner (rsp_type)
//
// Each rectangle yields four corners, one per cycle while rsp is not stalled, so one rectangle enters
// for every four corners out; that rate is set by the corner sequencer, which holds a rectangle until
// its last corner goes. The first corner passes the input register, two reduction stages, the held
// rectangle, the product stage and the output register. Reset is synchronous and active high; it empties every stage.
// A stall on rsp backs up through the product stage, the corner sequencer and three
// front stages; up to three rectangles wait upstream while one is being emitted.
module rectangle_rotate_about_center import rrac_pkg::*; #(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

`include "rectangle_rotate_about_center_assert.svh"

   logic                             trig_valid, trig_ready;
   logic signed [TRIG_FRAC_BITS+1:0] trig_sin, trig_cos;
   geom_type                         trig_geom;

   // Angle reduction and trig lookup.
   rrac_trig #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_trig (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .trig_valid (trig_valid),
      .trig_ready (trig_ready),
      .trig_sin   (trig_sin),
      .trig_cos   (trig_cos),
      .trig_geom  (trig_geom)
   );

   // Corner sequencing and output arithmetic.
   rrac_corner #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_corner (
      .clock      (clock),
      .reset      (reset),
      .trig_valid (trig_valid),
      .trig_ready (trig_ready),
      .trig_sin   (trig_sin),
      .trig_cos   (trig_cos),
      .trig_geom  (trig_geom),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // The last-corner flag marks corner three and nothing else.
   `RRAC_ASSERT_NOW(a_last_flag, rsp_valid, rsp.last_corner == (rsp.corner_index == LAST_CORNER), "last_corner does not match corner_index")
   // Input back-pressure only happens when the front pipeline is full and blocked.
   `RRAC_ASSERT_NOW(a_front_full, !req_ready, trig_valid && !trig_ready, "req_ready low while front pipeline can move")
   // Corners come out in order, wrapping from the last corner to the first.
   `RRAC_ASSERT_NEXT(a_corner_order, rsp_valid && rsp_ready, !rsp_valid || rsp.corner_index == $past(rsp.corner_index) + 2'd1, "corner sequence out of order")

endmodule

[bench/testbench.sv]
// Self-checking testbench for the rectangle corner rotation block.
module testbench import rrac_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Working precision of sine and cosine, matching the default build of the block.
   localparam int     TRIG_F     = TRIG_FRAC_BITS_DEF;
   localparam int     TRIG_DROP  = TABLE_FRAC - TRIG_F;
   localparam int     TRIG_ROUND = (1 << TRIG_DROP) >> 1;
   localparam longint TRIG_SCALE = longint'(1) << TRIG_F;
   localparam longint OUT_LOW    = -(longint'(1) << (OUT_BITS - 1));
   localparam longint OUT_HIGH   = (longint'(1) << (OUT_BITS - 1)) - 1;

   // Run shape and limits.
   localparam int RANDOM_RECTS   = 80;
   localparam int DRAIN_AT       = 40;
   localparam int HOLD_AT        = 120;
   localparam int HOLD_CYCLES    = 80;
   localparam int STALL_LIMIT    = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int DIRECTED_ROWS  = 23;

   // Independent sine table, sin(k degrees) for k = 0..90 with 16 fraction bits.
   localparam int SINE_Q16 [0:90] = '{
      0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
      11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
      22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
      32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
      42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
      50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
      56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
      61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
      64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
      65536
   };

   // One directed rectangle; the corners are typed in only where they are obvious.
   typedef struct packed {
      req_type                     stim;
      logic                        typed;
      logic [0:3][OUT_BITS-1:0]    want_x;
      logic [0:3][OUT_BITS-1:0]    want_y;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // No rotation leaves every corner in place.
      '{'{10'd0, 10'd0, 10'd1023, 10'd1023, 16'sd0}, 1'b1,
        {12'd0, 12'd0, 12'd1023, 12'd1023}, {12'd0, 12'd1023, 12'd1023, 12'd0}},
      '{'{10'd0, 10'd0, 10'd1023, 10'd1023, 16'sd360}, 1'b1,
        {12'd0, 12'd0, 12'd1023, 12'd1023}, {12'd0, 12'd1023, 12'd1023, 12'd0}},
      // Corners given in reverse order, full negative turn.
      '{'{10'd1023, 10'd1023, 10'd0, 10'd0, -16'sd360}, 1'b1,
        {12'd1023, 12'd1023, 12'd0, 12'd0}, {12'd1023, 12'd0, 12'd0, 12'd1023}},
      // Half turns swap opposite corners.
      '{'{10'd10, 10'd20, 10'd30, 10'd40, 16'sd180}, 1'b1,
        {12'd30, 12'd30, 12'd10, 12'd10}, {12'd40, 12'd20, 12'd20, 12'd40}},
      '{'{10'd10, 10'd20, 10'd30, 10'd40, -16'sd180}, 1'b1,
        {12'd30, 12'd30, 12'd10, 12'd10}, {12'd40, 12'd20, 12'd20, 12'd40}},
      // Odd coordinate sums: the truncated center shifts every corner one pixel down in x and y.
      '{'{10'd0, 10'd0, 10'd1023, 10'd1023, 16'sd180}, 1'b1,
        {12'd1022, 12'd1022, 12'hFFF, 12'hFFF}, {12'd1022, 12'hFFF, 12'hFFF, 12'd1022}},
      '{'{10'd10, 10'd20, 10'd30, 10'd40, 16'sd90}, 1'b0, '0, '0},
      '{'{10'd10, 10'd20, 10'd30, 10'd40, 16'sd270}, 1'b0, '0, '0},
      '{'{10'd0, 10'd0, 10'd1023, 10'd1023, 16'sd45}, 1'b0, '0, '0},
      '{'{10'd1023, 10'd0, 10'd0, 10'd1023, 16'sd1}, 1'b0, '0, '0},
      '{'{10'd512, 10'd512, 10'd700, 10'd300, 16'sd89}, 1'b0, '0, '0},
      '{'{10'd100, 10'd900, 10'd900, 10'd100, 16'sd91}, 1'b0, '0, '0},
      '{'{10'd0, 10'd1023, 10'd1023, 10'd0, 16'sd179}, 1'b0, '0, '0},
      '{'{10'd300, 10'd400, 10'd500, 10'd600, 16'sd181}, 1'b0, '0, '0},
      '{'{10'd5, 10'd6, 10'd1000, 10'd1010, 16'sd269}, 1'b0, '0, '0},
      '{'{10'd5, 10'd6, 10'd1000, 10'd1010, 16'sd271}, 1'b0, '0, '0},
      '{'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'sd359}, 1'b0, '0, '0},
      '{'{10'd0, 10'd0, 10'd0, 10'd0, -16'sd1}, 1'b0, '0, '0},
      // Largest and smallest angles of the field.
      '{'{10'd341, 10'd682, 10'd682, 10'd341, 16'sd32767}, 1'b0, '0, '0},
      '{'{10'd682, 10'd341, 10'd341, 10'd682, -16'sd32768}, 1'b0, '0, '0},
      '{'{10'd0, 10'd512, 10'd1023, 10'd511, -16'sd359}, 1'b0, '0, '0},
      '{'{10'd513, 10'd0, 10'd511, 10'd1023, -16'sd90}, 1'b0, '0, '0},
      '{'{10'd1023, 10'd1023, 10'd0, 10'd0, 16'sd135}, 1'b0, '0, '0}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp;

   rsp_type expected_corners [$];
   int      mismatch_count = 0;
   int      idle_cycles    = 0;
   bit      sender_calm    = 1'b0;
   bit      receiver_calm  = 1'b0;

   rectangle_rotate_about_center u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Reduce a table entry to the working precision, rounding half up.
   function automatic longint trig_entry(input int k);
      return longint'((SINE_Q16[k] + TRIG_ROUND) >> TRIG_DROP);
   endfunction

   // Truncate a scaled sum toward zero and clamp it to the output range.
   function automatic logic signed [OUT_BITS-1:0] scale_and_clip(input longint acc);
      longint whole;
      whole = acc / TRIG_SCALE;
      if (whole < OUT_LOW) whole = OUT_LOW;
      if (whole > OUT_HIGH) whole = OUT_HIGH;
      return whole[OUT_BITS-1:0];
   endfunction

   // Rotate the four corners of one rectangle about its center and queue the results.
   function automatic void rotate_corners(input req_type r);
      int     turn;
      int     quad;
      int     step;
      longint sin_v;
      longint cos_v;
      longint near_v;
      longint far_v;
      longint cx;
      longint cy;
      longint dx;
      longint dy;
      longint px [4];
      longint py [4];
      rsp_type corner;

      turn = int'($signed(r.angle_degrees)) % DEG_FULL;
      if (turn < 0) turn += DEG_FULL;
      quad   = turn / DEG_QUARTER;
      step   = turn % DEG_QUARTER;
      near_v = trig_entry(step);
      far_v  = trig_entry(DEG_QUARTER - step);

      // Quadrant symmetry of the quarter wave.
      case (quad)
         0: begin sin_v = near_v;  cos_v = far_v;   end
         1: begin sin_v = far_v;   cos_v = -near_v; end
         2: begin sin_v = -near_v; cos_v = -far_v;  end
         default: begin sin_v = -far_v; cos_v = near_v; end
      endcase

      cx = (longint'(r.left_x) + longint'(r.right_x)) >> 1;
      cy = (longint'(r.top_y) + longint'(r.bottom_y)) >> 1;
      px = '{longint'(r.left_x), longint'(r.left_x), longint'(r.right_x), longint'(r.right_x)};
      py = '{longint'(r.top_y), longint'(r.bottom_y), longint'(r.bottom_y), longint'(r.top_y)};

      // Outline order: first corner, then around through the opposite one.
      for (int i = 0; i < 4; i++) begin
         dx = px[i] - cx;
         dy = py[i] - cy;
         corner.corner_index = i[CORNER_BITS-1:0];
         corner.rotated_x    = scale_and_clip(cx * TRIG_SCALE + dx * cos_v - dy * sin_v);
         corner.rotated_y    = scale_and_clip(cy * TRIG_SCALE + dx * sin_v + dy * cos_v);
         corner.last_corner  = (i == int'(LAST_CORNER));
         expected_corners.push_back(corner);
      end
   endfunction

   // Idle cycles before the next transfer; none at all during a calm stretch.
   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 9));
   endfunction

   // Coordinate with a bias toward the ends of its range.
   function automatic coord_type pick_coord();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return coord_type'($urandom_range(0, 1023));
      endcase
   endfunction

   // Random rectangle with a mix of wide, moderate and quadrant-edge angles, and now and then a flat one.
   function automatic req_type random_rect();
      req_type r;
      int      spin;
      r.left_x   = pick_coord();
      r.top_y    = pick_coord();
      r.right_x  = pick_coord();
      r.bottom_y = pick_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: spin = int'($urandom_range(0, 65535));
         4, 5, 6:    spin = int'($urandom_range(0, 1440)) - 720;
         7, 8:       spin = 90 * int'($urandom_range(0, 8)) - 360
                            + int'($urandom_range(0, 2)) - 1;
         default: begin
            // Flat rectangle: both corners on one line.
            spin = int'($urandom_range(0, 359));
            if ($urandom_range(0, 1) == 0) r.right_x = r.left_x;
            else r.bottom_y = r.top_y;
         end
      endcase
      r.angle_degrees = spin[ANGLE_BITS-1:0];
      return r;
   endfunction

   // Offer one rectangle and, once the transfer happens, queue its expected corners.
   task automatic send_rect(input plan_row_type row, input int seq);
      int      gap;
      rsp_type corner;
      if (seq % 10 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      gap = draw_gap(sender_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req       <= row.stim;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (row.typed) begin
         for (int i = 0; i < 4; i++) begin
            corner.corner_index = i[CORNER_BITS-1:0];
            corner.rotated_x    = row.want_x[i];
            corner.rotated_y    = row.want_y[i];
            corner.last_corner  = (i == int'(LAST_CORNER));
            expected_corners.push_back(corner);
         end
      end else begin
         rotate_corners(row.stim);
      end
   endtask

   // Compare one received corner with the oldest expectation.
   task automatic check_corner(input rsp_type got);
      rsp_type want;
      if (expected_corners.size() == 0) begin
         $error("unexpected corner transfer: index %0d x %0d y %0d", got.corner_index,
                $signed(got.rotated_x), $signed(got.rotated_y));
         mismatch_count++;
         return;
      end
      want = expected_corners.pop_front();
      if (got.corner_index !== want.corner_index) begin
         $error("corner_index: expected %0d, actual %0d", want.corner_index, got.corner_index);
         mismatch_count++;
      end
      if (got.rotated_x !== want.rotated_x) begin
         $error("rotated_x: expected %0d, actual %0d", $signed(want.rotated_x),
                $signed(got.rotated_x));
         mismatch_count++;
      end
      if (got.rotated_y !== want.rotated_y) begin
         $error("rotated_y: expected %0d, actual %0d", $signed(want.rotated_y),
                $signed(got.rotated_y));
         mismatch_count++;
      end
      if (got.last_corner !== want.last_corner) begin
         $error("last_corner: expected %0d, actual %0d", want.last_corner, got.last_corner);
         mismatch_count++;
      end
   endtask

   // Result side: random back-pressure, one long hold, and checking of every transfer.
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 12 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
         gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(receiver_calm);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_corner(rsp);
         taken++;
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Request side: reset, directed table, random rectangles, then drain and report.
   initial begin
      plan_row_type row;
      int           seq;
      seq       = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_rect(DIRECTED_PLAN[i], seq);
         seq++;
      end

      for (int n = 0; n < RANDOM_RECTS; n++) begin
         // Once, let the block run completely dry before offering more.
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_corners.size() != 0);
         end
         row.stim   = random_rect();
         row.typed  = 1'b0;
         row.want_x = '0;
         row.want_y = '0;
         send_rect(row, seq);
         seq++;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (expected_corners.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
